FILE: hdl/u2c_pkg.sv
`timescale 1ns / 1ps
package u2c_pkg;

  localparam logic [7:0] QMARK = 8'd63;
  localparam logic [3:0] ST_ACCEPT = 4'd0;
  localparam logic [3:0] ST_REJECT = 4'd1;

  // one result word
  typedef struct packed {
    logic [7:0] cp437_char;
    logic       char_valid;
    logic       run_last;
    logic       string_end;
  } res_t;

  // byte class of a UTF-8 byte
  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] t;
    if (b < 8'h80) t = 4'd0;
    else if (b < 8'h90) t = 4'd1;
    else if (b < 8'hA0) t = 4'd9;
    else if (b < 8'hC0) t = 4'd7;
    else if (b < 8'hC2) t = 4'd8;
    else if (b < 8'hE0) t = 4'd2;
    else if (b == 8'hE0) t = 4'd10;
    else if (b == 8'hED) t = 4'd4;
    else if (b < 8'hF0) t = 4'd3;
    else if (b == 8'hF0) t = 4'd11;
    else if (b < 8'hF4) t = 4'd6;
    else if (b == 8'hF4) t = 4'd5;
    else t = 4'd8;
    return t;
  endfunction

  // automaton transition, 1 = reject
  function automatic logic [3:0] next_state(input logic [3:0] s, input logic [3:0] t);
    logic [3:0] ns;
    ns = ST_REJECT;
    case (s)
      4'd0: begin
        case (t)
          4'd0: ns = 4'd0;
          4'd2: ns = 4'd2;
          4'd3: ns = 4'd3;
          4'd4: ns = 4'd5;
          4'd5: ns = 4'd8;
          4'd6: ns = 4'd7;
          4'd10: ns = 4'd4;
          4'd11: ns = 4'd6;
          default: ns = ST_REJECT;
        endcase
      end
      4'd2: if (t == 4'd1 || t == 4'd7 || t == 4'd9) ns = 4'd0;
      4'd3: if (t == 4'd1 || t == 4'd7 || t == 4'd9) ns = 4'd2;
      4'd4: if (t == 4'd7) ns = 4'd2;
      4'd5: if (t == 4'd1 || t == 4'd9) ns = 4'd2;
      4'd6: if (t == 4'd7 || t == 4'd9) ns = 4'd3;
      4'd7: if (t == 4'd1 || t == 4'd7 || t == 4'd9) ns = 4'd3;
      4'd8: if (t == 4'd1) ns = 4'd3;
      default: ns = ST_REJECT;
    endcase
    return ns;
  endfunction

  // reverse CP437 lookup of a codepoint
  function automatic logic [7:0] map_cp437(input logic [20:0] cp);
    logic [7:0] r;
    r = QMARK;
    if (cp == 21'h0 || (cp >= 21'h20 && cp <= 21'h7E)) r = cp[7:0];
    else begin
      case (cp)
        21'h263A: r = 8'd1;   21'h263B: r = 8'd2;   21'h2665: r = 8'd3;
        21'h2666: r = 8'd4;   21'h2663: r = 8'd5;   21'h2660: r = 8'd6;
        21'h2022: r = 8'd7;   21'h25D8: r = 8'd8;   21'h25CB: r = 8'd9;
        21'h25D9: r = 8'd10;  21'h2642: r = 8'd11;  21'h2640: r = 8'd12;
        21'h266A: r = 8'd13;  21'h266B: r = 8'd14;  21'h263C: r = 8'd15;
        21'h25BA: r = 8'd16;  21'h25C4: r = 8'd17;  21'h2195: r = 8'd18;
        21'h203C: r = 8'd19;  21'h00B6: r = 8'd20;  21'h00A7: r = 8'd21;
        21'h25AC: r = 8'd22;  21'h21A8: r = 8'd23;  21'h2191: r = 8'd24;
        21'h2193: r = 8'd25;  21'h2192: r = 8'd26;  21'h2190: r = 8'd27;
        21'h221F: r = 8'd28;  21'h2194: r = 8'd29;  21'h25B2: r = 8'd30;
        21'h25BC: r = 8'd31;  21'h2302: r = 8'd127;
        21'hC7: r = 8'h80; 21'hFC: r = 8'h81; 21'hE9: r = 8'h82; 21'hE2: r = 8'h83;
        21'hE4: r = 8'h84; 21'hE0: r = 8'h85; 21'hE5: r = 8'h86; 21'hE7: r = 8'h87;
        21'hEA: r = 8'h88; 21'hEB: r = 8'h89; 21'hE8: r = 8'h8A; 21'hEF: r = 8'h8B;
        21'hEE: r = 8'h8C; 21'hEC: r = 8'h8D; 21'hC4: r = 8'h8E; 21'hC5: r = 8'h8F;
        21'hC9: r = 8'h90; 21'hE6: r = 8'h91; 21'hC6: r = 8'h92; 21'hF4: r = 8'h93;
        21'hF6: r = 8'h94; 21'hF2: r = 8'h95; 21'hFB: r = 8'h96; 21'hF9: r = 8'h97;
        21'hFF: r = 8'h98; 21'hD6: r = 8'h99; 21'hDC: r = 8'h9A; 21'hA2: r = 8'h9B;
        21'hA3: r = 8'h9C; 21'hA5: r = 8'h9D; 21'h20A7: r = 8'h9E; 21'h192: r = 8'h9F;
        21'hE1: r = 8'hA0; 21'hED: r = 8'hA1; 21'hF3: r = 8'hA2; 21'hFA: r = 8'hA3;
        21'hF1: r = 8'hA4; 21'hD1: r = 8'hA5; 21'hAA: r = 8'hA6; 21'hBA: r = 8'hA7;
        21'hBF: r = 8'hA8; 21'h2310: r = 8'hA9; 21'hAC: r = 8'hAA; 21'hBD: r = 8'hAB;
        21'hBC: r = 8'hAC; 21'hA1: r = 8'hAD; 21'hAB: r = 8'hAE; 21'hBB: r = 8'hAF;
        21'h2591: r = 8'hB0; 21'h2592: r = 8'hB1; 21'h2593: r = 8'hB2; 21'h2502: r = 8'hB3;
        21'h2524: r = 8'hB4; 21'h2561: r = 8'hB5; 21'h2562: r = 8'hB6; 21'h2556: r = 8'hB7;
        21'h2555: r = 8'hB8; 21'h2563: r = 8'hB9; 21'h2551: r = 8'hBA; 21'h2557: r = 8'hBB;
        21'h255D: r = 8'hBC; 21'h255C: r = 8'hBD; 21'h255B: r = 8'hBE; 21'h2510: r = 8'hBF;
        21'h2514: r = 8'hC0; 21'h2534: r = 8'hC1; 21'h252C: r = 8'hC2; 21'h251C: r = 8'hC3;
        21'h2500: r = 8'hC4; 21'h253C: r = 8'hC5; 21'h255E: r = 8'hC6; 21'h255F: r = 8'hC7;
        21'h255A: r = 8'hC8; 21'h2554: r = 8'hC9; 21'h2569: r = 8'hCA; 21'h2566: r = 8'hCB;
        21'h2560: r = 8'hCC; 21'h2550: r = 8'hCD; 21'h256C: r = 8'hCE; 21'h2567: r = 8'hCF;
        21'h2568: r = 8'hD0; 21'h2564: r = 8'hD1; 21'h2565: r = 8'hD2; 21'h2559: r = 8'hD3;
        21'h2558: r = 8'hD4; 21'h2552: r = 8'hD5; 21'h2553: r = 8'hD6; 21'h256B: r = 8'hD7;
        21'h256A: r = 8'hD8; 21'h2518: r = 8'hD9; 21'h250C: r = 8'hDA; 21'h2588: r = 8'hDB;
        21'h2584: r = 8'hDC; 21'h258C: r = 8'hDD; 21'h2590: r = 8'hDE; 21'h2580: r = 8'hDF;
        21'h3B1: r = 8'hE0; 21'hDF: r = 8'hE1; 21'h393: r = 8'hE2; 21'h3C0: r = 8'hE3;
        21'h3A3: r = 8'hE4; 21'h3C3: r = 8'hE5; 21'hB5: r = 8'hE6; 21'h3C4: r = 8'hE7;
        21'h3A6: r = 8'hE8; 21'h398: r = 8'hE9; 21'h3A9: r = 8'hEA; 21'h3B4: r = 8'hEB;
        21'h221E: r = 8'hEC; 21'h3C6: r = 8'hED; 21'h3B5: r = 8'hEE; 21'h2229: r = 8'hEF;
        21'h2261: r = 8'hF0; 21'hB1: r = 8'hF1; 21'h2265: r = 8'hF2; 21'h2264: r = 8'hF3;
        21'h2320: r = 8'hF4; 21'h2321: r = 8'hF5; 21'hF7: r = 8'hF6; 21'h2248: r = 8'hF7;
        21'hB0: r = 8'hF8; 21'h2219: r = 8'hF9; 21'hB7: r = 8'hFA; 21'h221A: r = 8'hFB;
        21'h207F: r = 8'hFC; 21'hB2: r = 8'hFD; 21'h25A0: r = 8'hFE; 21'hA0: r = 8'hFF;
        default: r = QMARK;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: hdl/u2c_step.sv
`timescale 1ns / 1ps
// Decode step: one byte against the automaton state, gives up to two results.
module u2c_step (
  input  logic [7:0]        byte_in,
  input  logic              string_last,
  input  logic [3:0]        dfa_state,
  input  logic [20:0]       codepoint_acc,
  output logic [3:0]        dfa_state_next,
  output logic [20:0]       codepoint_acc_next,
  output logic [1:0]        count,
  output u2c_pkg::res_t     res0,
  output u2c_pkg::res_t     res1
);
  import u2c_pkg::*;

  logic [3:0]  t;
  logic [7:0]  lead_bits;
  logic [3:0]  ns1, ns2;
  logic [20:0] acc1, acc2;
  logic        retry;

  always_comb begin
    t         = byte_class(byte_in);
    lead_bits = (8'hFF >> t) & byte_in;
    acc1 = (dfa_state != ST_ACCEPT) ? {codepoint_acc[14:0], byte_in[5:0]}
                                    : {13'd0, lead_bits};
    ns1  = next_state(dfa_state, t);
    acc2 = {13'd0, lead_bits};
    ns2  = next_state(ST_ACCEPT, t);
    retry = (ns1 == ST_REJECT) && (dfa_state != ST_ACCEPT);

    res0 = '0;
    res1 = '0;
    count = 2'd0;
    dfa_state_next     = ns1;
    codepoint_acc_next = acc1;
    // first pass
    if (ns1 == ST_ACCEPT) begin
      res0 = '{map_cp437(acc1), 1'b1, 1'b0, 1'b0};
      count = 2'd1;
    end else if (ns1 == ST_REJECT) begin
      res0 = '{QMARK, 1'b1, 1'b0, 1'b0};
      count = 2'd1;
      dfa_state_next = ST_ACCEPT;
    end
    // second pass from accept
    if (retry) begin
      codepoint_acc_next = acc2;
      dfa_state_next     = ns2;
      if (ns2 == ST_ACCEPT) begin
        res1 = '{map_cp437(acc2), 1'b1, 1'b0, 1'b0};
        count = 2'd2;
      end else if (ns2 == ST_REJECT) begin
        res1 = '{QMARK, 1'b1, 1'b0, 1'b0};
        count = 2'd2;
        dfa_state_next = ST_ACCEPT;
      end
    end
    // string end
    if (string_last) begin
      dfa_state_next     = ST_ACCEPT;
      codepoint_acc_next = '0;
      if (count == 2'd0) begin
        res0  = '{8'd0, 1'b0, 1'b0, 1'b0};
        count = 2'd1;
      end
    end
    if (count == 2'd2) begin
      res1.run_last   = 1'b1;
      res1.string_end = string_last;
    end else begin
      res0.run_last   = 1'b1;
      res0.string_end = string_last;
    end
  end

endmodule

FILE: hdl/utf8_to_cp437_decoder.sv
`timescale 1ns / 1ps
// UTF-8 to CP437 stream decoder. One byte word is taken per cycle while the
// output slot is free and no second result is pending; a word yields zero,
// one or two CP437 words. A byte that gives two results blocks input until
// its second result moves into the output register. Results are registered
// as the byte is accepted. s_tuser flags the string's last byte; results
// carry run_last on tlast and {string_end, char_valid} on tuser.
module utf8_to_cp437_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // byte_in
  input  logic       s_tuser,   // string_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // cp437_char
  output logic       m_tlast,   // run_last
  output logic [1:0] m_tuser    // char_valid, string_end
);
  import u2c_pkg::*;

  logic [3:0]  dfa_state, dfa_state_next;
  logic [20:0] codepoint_acc, codepoint_acc_next;
  logic [1:0]  count;
  res_t        res0, res1;
  res_t        out_reg, pend;
  logic        out_valid, pend_valid;
  logic        accept, adv;

  u2c_step u_step (
    .byte_in(s_tdata), .string_last(s_tuser),
    .dfa_state(dfa_state), .codepoint_acc(codepoint_acc),
    .dfa_state_next(dfa_state_next), .codepoint_acc_next(codepoint_acc_next),
    .count(count), .res0(res0), .res1(res1)
  );

  // output slot frees when empty or taken; pending second result blocks input
  assign adv      = !out_valid || m_tready;
  assign s_tready = adv && !pend_valid;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state     <= ST_ACCEPT;
      codepoint_acc <= '0;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      if (accept) begin
        dfa_state     <= dfa_state_next;
        codepoint_acc <= codepoint_acc_next;
      end
      if (adv) begin
        if (pend_valid) begin
          out_reg    <= pend;
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (accept && count != 2'd0) begin
          out_reg    <= res0;
          out_valid  <= 1'b1;
          pend       <= res1;
          pend_valid <= (count == 2'd2);
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg.cp437_char;
  assign m_tlast  = out_reg.run_last;
  assign m_tuser  = {out_reg.string_end, out_reg.char_valid};

endmodule

FILE: hdl/u2c_checker.sv
`timescale 1ns / 1ps
module u2c_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);
  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser)) else $error("output word changed under stall");
  // string end only on a run's last word
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast) else $error("string_end without run_last");
  // an end-only marker has a zero byte
  a_dummy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0 && m_tuser[1])
    else $error("bad end marker");
  // nothing leaves straight after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");
endmodule

bind utf8_to_cp437_decoder u2c_checker u_chk (
  .clk(clk), .rst(rst),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .m_tlast(m_tlast), .m_tuser(m_tuser)
);

FILE: bench/tb_utf8_to_cp437_decoder.sv
`timescale 1ns / 1ps
module tb_utf8_to_cp437_decoder;
  import u2c_pkg::*;

  localparam int HOLD_LIMIT = 5000;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  utf8_to_cp437_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  // decoder state mirror and pending results
  logic [3:0]  utf_state;
  logic [20:0] cp_acc;
  res_t        char_queue[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_cycles;
  bit          failed;
  bit          done_sending;

  initial begin
    clk = 1'b0;
  end
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // class of a byte, written out from the UTF-8 lead and trail ranges
  function automatic logic [3:0] utf_class(input logic [7:0] b);
    if (b < 8'h80) return 4'd0;
    if (b < 8'h90) return 4'd1;
    if (b < 8'hA0) return 4'd9;
    if (b < 8'hC0) return 4'd7;
    if (b < 8'hC2) return 4'd8;
    if (b < 8'hE0) return 4'd2;
    if (b == 8'hE0) return 4'd10;
    if (b == 8'hED) return 4'd4;
    if (b < 8'hF0) return 4'd3;
    if (b == 8'hF0) return 4'd11;
    if (b < 8'hF4) return 4'd6;
    if (b == 8'hF4) return 4'd5;
    return 4'd8;
  endfunction

  function automatic logic [3:0] utf_next(input logic [3:0] s, input logic [3:0] t);
    logic [3:0] trans[9][12];
    trans[0] = '{0, 1, 2, 3, 5, 8, 7, 1, 1, 1, 4, 6};
    trans[1] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1};
    trans[2] = '{1, 0, 1, 1, 1, 1, 1, 0, 1, 0, 1, 1};
    trans[3] = '{1, 2, 1, 1, 1, 1, 1, 2, 1, 2, 1, 1};
    trans[4] = '{1, 1, 1, 1, 1, 1, 1, 2, 1, 1, 1, 1};
    trans[5] = '{1, 2, 1, 1, 1, 1, 1, 1, 1, 2, 1, 1};
    trans[6] = '{1, 1, 1, 1, 1, 1, 1, 3, 1, 3, 1, 1};
    trans[7] = '{1, 3, 1, 1, 1, 1, 1, 3, 1, 3, 1, 1};
    trans[8] = '{1, 3, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1};
    if (s > 4'd8 || t > 4'd11) return ST_REJECT;
    return trans[s][t];
  endfunction

  // CP437 code page as Unicode codepoints
  function automatic logic [15:0] page_uni(input int i);
    logic [15:0] lo[32];
    logic [15:0] hi[128];
    lo = '{16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
           16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
           16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
           16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC};
    hi = '{16'hC7, 16'hFC, 16'hE9, 16'hE2, 16'hE4, 16'hE0, 16'hE5, 16'hE7,
           16'hEA, 16'hEB, 16'hE8, 16'hEF, 16'hEE, 16'hEC, 16'hC4, 16'hC5,
           16'hC9, 16'hE6, 16'hC6, 16'hF4, 16'hF6, 16'hF2, 16'hFB, 16'hF9,
           16'hFF, 16'hD6, 16'hDC, 16'hA2, 16'hA3, 16'hA5, 16'h20A7, 16'h192,
           16'hE1, 16'hED, 16'hF3, 16'hFA, 16'hF1, 16'hD1, 16'hAA, 16'hBA,
           16'hBF, 16'h2310, 16'hAC, 16'hBD, 16'hBC, 16'hA1, 16'hAB, 16'hBB,
           16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
           16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
           16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
           16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
           16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
           16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
           16'h3B1, 16'hDF, 16'h393, 16'h3C0, 16'h3A3, 16'h3C3, 16'hB5, 16'h3C4,
           16'h3A6, 16'h398, 16'h3A9, 16'h3B4, 16'h221E, 16'h3C6, 16'h3B5, 16'h2229,
           16'h2261, 16'hB1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'hF7, 16'h2248,
           16'hB0, 16'h2219, 16'hB7, 16'h221A, 16'h207F, 16'hB2, 16'h25A0, 16'hA0};
    if (i < 32) return lo[i];
    if (i == 127) return 16'h2302;
    if (i < 128) return 16'(i);
    return hi[i - 128];
  endfunction

  function automatic logic [7:0] to_cp437(input logic [20:0] cp);
    if (cp < 21'd256 && page_uni(int'(cp)) == cp[15:0]) return cp[7:0];
    for (int i = 1; i < 256; i++)
      if (page_uni(i) != 16'(i) && {5'd0, page_uni(i)} == cp) return 8'(i);
    return QMARK;
  endfunction

  // work out the CP437 words one accepted byte yields
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [3:0] s;
    logic [3:0] t;
    logic [3:0] ns;
    logic       was_inside;
    res_t       r;
    res_t       out[$];
    s = utf_state;
    was_inside = (s != ST_ACCEPT);
    for (int pass = 0; pass < 2; pass++) begin
      t = utf_class(b);
      if (s != ST_ACCEPT) cp_acc = {cp_acc[14:0], b[5:0]};
      else cp_acc = 21'(b & (8'hFF >> t));
      ns = utf_next(s, t);
      if (ns == ST_ACCEPT) begin
        r = '{cp437_char: to_cp437(cp_acc), char_valid: 1'b1, run_last: 1'b0, string_end: 1'b0};
        out = {out, r};
        s = ST_ACCEPT;
        break;
      end
      if (ns == ST_REJECT) begin
        r = '{cp437_char: QMARK, char_valid: 1'b1, run_last: 1'b0, string_end: 1'b0};
        out = {out, r};
        s = ST_ACCEPT;
        if (was_inside && pass == 0) continue;
        break;
      end
      s = ns;
      break;
    end
    utf_state = s;
    if (last) begin
      utf_state = ST_ACCEPT;
      cp_acc = '0;
      if (out.size() == 0) begin
        r = '{cp437_char: 8'd0, char_valid: 1'b0, run_last: 1'b0, string_end: 1'b0};
        out = {out, r};
      end
      out[out.size() - 1].string_end = 1'b1;
    end
    if (out.size() > 0) out[out.size() - 1].run_last = 1'b1;
    foreach (out[i]) char_queue = {char_queue, out[i]};
  endtask

  // send one byte word; predict on acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b, last);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (char_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver stall and result check
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (char_queue.size() == 0) begin
          $display("%0t unexpected word: actual char=%h valid=%b last=%b end=%b",
                   $time, m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
          failed = 1'b1;
        end else begin
          res_t e;
          e = char_queue.pop_front();
          if (m_tdata != e.cp437_char || m_tuser[0] != e.char_valid ||
              m_tlast != e.run_last || m_tuser[1] != e.string_end) begin
            $display("%0t mismatch: expected char=%h valid=%b last=%b end=%b",
                     $time, e.cp437_char, e.char_valid, e.run_last, e.string_end);
            $display("%0t           actual   char=%h valid=%b last=%b end=%b",
                     $time, m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
            failed = 1'b1;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else if (!done_sending || char_queue.size() != 0) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= HOLD_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // directed: extremes, each lead kind but F1 to F3, rejects and string ends
  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);           // e-acute
    send_byte(8'hE2, 1'b0); send_byte(8'h96, 1'b0); send_byte(8'h88, 1'b0);
    send_byte(8'hE0, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);                                 // unmapped 4-byte
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hC3, 1'b0);         // reject, then new lead
    send_byte(8'hE2, 1'b1);                                  // dangling lead at end
    send_byte(8'hFF, 1'b1);                                  // lone invalid at end
    send_byte(8'h80, 1'b0);
    send_byte(8'h20, 1'b1);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // random strings, mostly well-formed sequences, some noise
  task automatic test_random(input int n_bytes);
    int sent;
    int kind;
    int idx;
    logic [15:0] u;
    logic [7:0] seq[$];
    sent = 0;
    while (sent < n_bytes) begin
      seq.delete();
      kind = $urandom_range(9);
      case (kind)
        0, 1: seq = {seq, 8'($urandom_range(127))};
        2: begin
          idx = $urandom_range(255);
          u = page_uni(idx);
          if (u < 16'h80) seq = {seq, u[7:0]};
          else if (u < 16'h800) begin
            seq = {seq, 8'hC0 | 8'(u >> 6)};
            seq = {seq, 8'h80 | 8'(u & 16'h3F)};
          end else begin
            seq = {seq, 8'hE0 | 8'(u >> 12)};
            seq = {seq, 8'h80 | 8'((u >> 6) & 16'h3F)};
            seq = {seq, 8'h80 | 8'(u & 16'h3F)};
          end
        end
        3: begin seq = {seq, 8'($urandom_range(8'hDF, 8'hC2))}; seq = {seq, cont_byte()}; end
        4: begin
          seq = {seq, 8'($urandom_range(8'hEF, 8'hE0))};
          seq = {seq, cont_byte()}; seq = {seq, cont_byte()};
        end
        5: begin
          seq = {seq, 8'($urandom_range(8'hF4, 8'hF0))};
          seq = {seq, cont_byte()}; seq = {seq, cont_byte()}; seq = {seq, cont_byte()};
        end
        6: begin
          // truncated sequence
          seq = {seq, 8'($urandom_range(8'hF4, 8'hC2))};
          if ($urandom_range(1)) seq = {seq, cont_byte()};
        end
        default: seq = {seq, 8'($urandom_range(255))};
      endcase
      foreach (seq[i]) begin
        send_byte(seq[i], ($urandom_range(15) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    utf_state = ST_ACCEPT;
    cp_acc = '0;
    failed = 1'b0;
    done_sending = 1'b0;
    stall_cycles = 0;
    send_idle_pct = 26;
    recv_idle_pct = 68;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    wait_drained();
    test_random(600);
    send_byte(8'h2E, 1'b1);
    wait_drained();
    send_idle_pct = 68;
    recv_idle_pct = 26;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(600);
    send_byte(8'h2E, 1'b1);

    done_sending = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk);
    if (failed || char_queue.size() != 0) begin
      $display("Mismatches found");
    end else begin
      $display("No mismatches found");
    end
    $finish;
  end

endmodule
